// ----- hw/rtl/mccf_pkg.sv -----
// Package with the item types, kind codes and entry layout of the match cross-check filter.
`default_nettype none

package mccf_pkg;

  localparam int IDX_W             = 13;
  localparam int DIST_W            = 32;
  localparam int TAG_W             = 8;
  localparam int MAX_KEYPOINTS_DEF = 8192;

  localparam logic [1:0] KIND_STORE = 2'd0;
  localparam logic [1:0] KIND_PROBE = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // Epoch value written into every entry by the clearing sweep; it never
  // matches the running epoch.
  localparam logic [TAG_W-1:0] TAG_EMPTY = '0;
  localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
  localparam logic [TAG_W-1:0] TAG_LAST  = '1;

  typedef struct packed {
    logic [1:0]        kind;
    logic [IDX_W-1:0]  query_index;
    logic [IDX_W-1:0]  train_index;
    logic [DIST_W-1:0] distance;
  } match_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  kept_query_index;
    logic [IDX_W-1:0]  kept_train_index;
    logic [DIST_W-1:0] kept_distance;
  } match_out_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [IDX_W-1:0]  partner;
    logic [DIST_W-1:0] best_dist;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             sweeping;
    logic [TAG_W-1:0] epoch;
  } epoch_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mccf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mccf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mccf_ctrl.sv -----
// Epoch counter and clearing sweep that stand in for the per-entry valid marks.
`default_nettype none

module mccf_ctrl #(
  parameter int MAX_KEYPOINTS = mccf_pkg::MAX_KEYPOINTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             clear_req,
  output mccf_pkg::epoch_stat_t                 stat,
  output logic      [$clog2(MAX_KEYPOINTS)-1:0] sweep_addr
);

  import mccf_pkg::*;

  localparam int AW = $clog2(MAX_KEYPOINTS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_KEYPOINTS - 1);

  typedef enum logic {
    S_SWEEP,
    S_RUN
  } state_t;

  state_t           state;
  logic [TAG_W-1:0] epoch;
  logic [AW-1:0]    cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      epoch <= TAG_FIRST;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_SWEEP: begin
          cnt <= cnt + AW'(1);
          if (cnt == LAST_ADDR) begin
            state <= S_RUN;
            epoch <= TAG_FIRST;
          end
        end
        S_RUN: begin
          // A clear normally just moves to a fresh epoch; only when the
          // epoch space is used up does the table get swept again.
          if (clear_req) begin
            if (epoch == TAG_LAST) begin
              state <= S_SWEEP;
              cnt   <= '0;
            end else begin
              epoch <= epoch + TAG_W'(1);
            end
          end
        end
        default: state <= S_SWEEP;
      endcase
    end
  end

  assign stat.sweeping = (state == S_SWEEP);
  assign stat.epoch    = epoch;
  assign sweep_addr    = cnt;

endmodule

`default_nettype wire

// ----- hw/rtl/match_cross_check_filter.sv -----
// Top level of the mutual nearest-neighbor match cross-check filter.
//
//   channel  | signals                     | transfer
//   ---------+-----------------------------+------------------------------------
//   item in  | start, busy, item           | edge with start high and busy low
//   result   | result_valid, result        | edge ending the one-cycle strobe
//
// One item is taken per cycle while busy is low; a forward match that passes
// goes through the s1 register and then the result register. A clear item blocks intake while it sits in s1.
// Entries are tagged with an 8-bit epoch; reset, and every 255th clear,
// runs a sweep over all MAX_KEYPOINTS entries with busy high. The table
// RAM's single read and single write port set the rate.
// The receiver cannot stall, so results never wait.
`default_nettype none

module match_cross_check_filter #(
  parameter int MAX_KEYPOINTS = mccf_pkg::MAX_KEYPOINTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire mccf_pkg::match_in_t item,
  output logic                     result_valid,
  output mccf_pkg::match_out_t     result
);

  import mccf_pkg::*;

  localparam int AW = $clog2(MAX_KEYPOINTS);

  epoch_stat_t stat;
  logic [AW-1:0] sweep_addr;

  logic          accept;
  logic          s1_valid;
  match_in_t     s1_item;
  logic          clear_req;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] s1_addr;
  logic [IDX_W-1:0] s1_key;
  logic          s1_in_range;
  entry_t        ram_rdata;
  entry_t        cur;
  logic          hit;

  logic          upd_we;
  entry_t        upd_entry;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;

  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  entry_t        fwd_entry;

  logic          hit_probe;

  mccf_ctrl #(
    .MAX_KEYPOINTS(MAX_KEYPOINTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .clear_req (clear_req),
    .stat      (stat),
    .sweep_addr(sweep_addr)
  );

  assign clear_req = s1_valid && (s1_item.kind == KIND_CLEAR);
  assign busy      = stat.sweeping || clear_req;
  assign accept    = start && !busy;

  // A store looks up its image-1 keypoint (train side), a probe its query side.
  assign rd_addr = (item.kind == KIND_STORE) ? AW'(item.train_index) : AW'(item.query_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_item <= item;
    end
  end

  assign s1_key      = (s1_item.kind == KIND_STORE) ? s1_item.train_index : s1_item.query_index;
  assign s1_addr     = AW'(s1_key);
  assign s1_in_range = (32'(s1_key) < MAX_KEYPOINTS);

  // The registered read data misses a write made in the previous cycle; forward it.
  assign cur = (fwd_valid && (fwd_addr == s1_addr)) ? fwd_entry : ram_rdata;
  assign hit = (cur.tag == stat.epoch);

  assign upd_we = s1_valid && (s1_item.kind == KIND_STORE) && s1_in_range
                  && (!hit || (s1_item.distance < cur.best_dist));
  assign upd_entry.tag       = stat.epoch;
  assign upd_entry.partner   = s1_item.query_index;
  assign upd_entry.best_dist = s1_item.distance;

  assign hit_probe = s1_valid && (s1_item.kind == KIND_PROBE) && s1_in_range
                     && hit && (cur.partner == s1_item.train_index);

  always_comb begin
    if (stat.sweeping) begin
      ram_we              = 1'b1;
      ram_waddr           = sweep_addr;
      ram_wdata.tag       = TAG_EMPTY;
      ram_wdata.partner   = '0;
      ram_wdata.best_dist = '0;
    end else begin
      ram_we    = upd_we;
      ram_waddr = s1_addr;
      ram_wdata = upd_entry;
    end
  end

  mccf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_KEYPOINTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      fwd_valid    <= upd_we && !stat.sweeping;
      result_valid <= hit_probe;
    end
    fwd_addr  <= s1_addr;
    fwd_entry <= upd_entry;
    result.kept_query_index <= s1_item.query_index;
    result.kept_train_index <= s1_item.train_index;
    result.kept_distance    <= s1_item.distance;
  end

endmodule

`default_nettype wire

// ----- dv/tb_match_cross_check_filter.sv -----
// Self-checking testbench for the match cross-check filter: directed table, then random match lists.
`timescale 1ns / 100ps

module tb_match_cross_check_filter;
  import mccf_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;  // unused kind, must have no effect
  localparam int NUM_KEYPOINTS = MAX_KEYPOINTS_DEF;
  localparam int POOL          = 8;
  localparam int TAIL_CYCLES   = 8;
  localparam int STALL_LIMIT   = 40000;
  localparam int MAX_REPORTS   = 10;
  localparam int FRAME_ITEMS   = 650;
  localparam int STORM_ITEMS   = 300;

  typedef struct {
    match_in_t it;
    bit        typed;
    bit        hit;
  } dir_row_t;

  logic       clk   = 1'b0;
  logic       rst   = 1'b1;
  logic       start = 1'b0;
  match_in_t  item  = '0;
  logic       busy;
  logic       result_valid;
  match_out_t result;

  match_cross_check_filter dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the match table, indexed by the image-1 keypoint.
  bit [NUM_KEYPOINTS-1:0] slot_valid;
  logic [IDX_W-1:0]       slot_partner [NUM_KEYPOINTS];
  logic [DIST_W-1:0]      slot_dist    [NUM_KEYPOINTS];

  match_out_t       kept_matches [$];
  dir_row_t         directed_rows [$];
  logic [IDX_W-1:0] img1_pool [POOL];
  logic [IDX_W-1:0] img2_pool [POOL];
  int unsigned      mismatches   = 0;
  int unsigned      items_sent   = 0;
  int unsigned      burst_left   = 0;
  int unsigned      stall_cycles = 0;

  // Applies one item to the table mirror; returns 1 when a forward match survives.
  function automatic bit cross_check(input match_in_t it, output match_out_t kept);
    kept = {it.query_index, it.train_index, it.distance};
    case (it.kind)
      KIND_CLEAR: slot_valid = '0;
      KIND_STORE: begin
        if (!slot_valid[it.train_index] || it.distance < slot_dist[it.train_index]) begin
          slot_valid[it.train_index]   = 1'b1;
          slot_partner[it.train_index] = it.query_index;
          slot_dist[it.train_index]    = it.distance;
        end
      end
      KIND_PROBE: return slot_valid[it.query_index] && slot_partner[it.query_index] == it.train_index;
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic dir_row_t row(input logic [1:0] kind, input logic [IDX_W-1:0] q,
                                   input logic [IDX_W-1:0] t, input logic [DIST_W-1:0] d,
                                   input bit typed, input bit hit);
    row.it    = {kind, q, t, d};
    row.typed = typed;
    row.hit   = hit;
  endfunction

  function automatic match_in_t clear_item();
    return {KIND_CLEAR, IDX_W'($urandom), IDX_W'($urandom), DIST_W'($urandom)};
  endfunction

  // Small values and values near the top make ties and replacements frequent.
  function automatic logic [DIST_W-1:0] pick_distance();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return DIST_W'($urandom_range(0, 3));
    if (r == 3) return '1 - DIST_W'($urandom_range(0, 2));
    return DIST_W'($urandom);
  endfunction

  function automatic match_in_t pick_match(input int unsigned store_pct);
    match_in_t   it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it.distance = pick_distance();
    if (r < store_pct) begin
      it.kind        = KIND_STORE;
      it.query_index = img2_pool[$urandom_range(0, POOL - 1)];
      it.train_index = img1_pool[$urandom_range(0, POOL - 1)];
    end else if (r < 92) begin
      it.kind        = KIND_PROBE;
      it.query_index = img1_pool[$urandom_range(0, POOL - 1)];
      if (slot_valid[it.query_index] && $urandom_range(0, 1) == 1) begin
        it.train_index = slot_partner[it.query_index];
      end else if ($urandom_range(0, 9) == 0) begin
        it.train_index = IDX_W'($urandom);
      end else begin
        it.train_index = img2_pool[$urandom_range(0, POOL - 1)];
      end
    end else begin
      it.kind        = (r < 96) ? KIND_NONE : 2'($urandom_range(0, 2));
      it.query_index = IDX_W'($urandom);
      it.train_index = IDX_W'($urandom);
      it.distance    = DIST_W'($urandom);
    end
    return it;
  endfunction

  function automatic void refill_pools();
    for (int i = 0; i < POOL; i++) begin
      img1_pool[i] = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
                                                 : IDX_W'($urandom);
      img2_pool[i] = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
                                                 : IDX_W'($urandom);
    end
  endfunction

  // Holds the item on the bus until its transfer, then records what it should produce.
  task automatic push_item(input match_in_t it, input bit typed = 1'b0,
                           input bit typed_hit = 1'b0);
    match_out_t kept;
    bit         hit;
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    hit = cross_check(it, kept);
    if (typed) hit = typed_hit;
    if (hit) kept_matches.push_back(kept);
    items_sent++;
  endtask

  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Always waits on the clock before checking, so start is not driven twice in one step.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (kept_matches.size() != 0);
  endtask

  initial begin
    int unsigned frame_len;
    bit          paused;
    paused = 1'b0;
    directed_rows = '{
      row(KIND_PROBE, 13'h0000, 13'h0000, 32'h0000_0000, 1, 0),
      row(KIND_STORE, 13'h1FFF, 13'h0000, 32'hFFFF_FFFF, 0, 0),
      row(KIND_PROBE, 13'h0000, 13'h1FFF, 32'h0000_0000, 1, 1),
      row(KIND_STORE, 13'h0005, 13'h0000, 32'hFFFF_FFFF, 0, 0),
      row(KIND_PROBE, 13'h0000, 13'h0005, 32'h0000_0001, 1, 0),
      row(KIND_PROBE, 13'h0000, 13'h1FFF, 32'hFFFF_FFFF, 1, 1),
      row(KIND_STORE, 13'h0005, 13'h0000, 32'hFFFF_FFFE, 0, 0),
      row(KIND_PROBE, 13'h0000, 13'h0005, 32'h1234_5678, 1, 1),
      row(KIND_STORE, 13'h0000, 13'h1FFF, 32'h0000_0000, 0, 0),
      row(KIND_PROBE, 13'h1FFF, 13'h0000, 32'hFFFF_FFFF, 1, 1),
      row(KIND_STORE, 13'h0001, 13'h1FFF, 32'h0000_0000, 0, 0),
      row(KIND_PROBE, 13'h1FFF, 13'h0001, 32'h0000_0000, 1, 0),
      row(KIND_NONE,  13'h1FFF, 13'h0000, 32'h0000_0000, 1, 0),
      row(KIND_PROBE, 13'h1FFF, 13'h0000, 32'h0000_0000, 1, 1),
      row(KIND_CLEAR, 13'h1FFF, 13'h1FFF, 32'hFFFF_FFFF, 1, 0),
      row(KIND_PROBE, 13'h0000, 13'h0005, 32'h0000_0000, 1, 0),
      row(KIND_PROBE, 13'h1FFF, 13'h0000, 32'h0000_0000, 1, 0),
      row(KIND_STORE, 13'h0AAA, 13'h1555, 32'h8000_0000, 0, 0),
      row(KIND_PROBE, 13'h1555, 13'h0AAA, 32'h5555_5555, 1, 1),
      row(KIND_STORE, 13'h1555, 13'h0AAA, 32'h7FFF_FFFF, 0, 0),
      row(KIND_PROBE, 13'h0AAA, 13'h1555, 32'hAAAA_AAAA, 1, 1),
      row(KIND_STORE, 13'h0003, 13'h0007, 32'h0000_0064, 0, 0),
      row(KIND_PROBE, 13'h0007, 13'h0003, 32'h0000_0000, 1, 1),
      row(KIND_STORE, 13'h0004, 13'h0007, 32'h0000_0063, 0, 0),
      row(KIND_PROBE, 13'h0007, 13'h0004, 32'h0000_0010, 1, 1),
      row(KIND_PROBE, 13'h0007, 13'h0003, 32'h0000_0000, 1, 0)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed rows go back to back so a store is followed at once by its probe.
    foreach (directed_rows[i]) begin
      push_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].hit);
    end
    drain();

    // Match lists of random length, each opened by a clear as for a new image pair.
    while (items_sent < directed_rows.size() + FRAME_ITEMS) begin
      refill_pools();
      push_item(clear_item());
      pace();
      frame_len = $urandom_range(4, 40);
      repeat (frame_len) begin
        push_item(pick_match(45));
        pace();
      end
      if (!paused && items_sent >= 350) begin
        drain();
        paused = 1'b1;
      end
    end

    // Mostly clears, enough to wrap the entry epoch and force a sweep.
    refill_pools();
    repeat (STORM_ITEMS) begin
      push_item(($urandom_range(0, 99) < 85) ? clear_item() : pick_match(50));
      pace();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && kept_matches.size() == 0) begin
      $display("match_cross_check_filter test passed");
    end else begin
      $display("match_cross_check_filter test failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    match_out_t want;
    if (!rst && result_valid !== 1'b0) begin
      if (kept_matches.size() == 0) begin
        if (mismatches < MAX_REPORTS) begin
          $display("unexpected result: q=%0d t=%0d d=%h", result.kept_query_index,
                   result.kept_train_index, result.kept_distance);
        end
        mismatches++;
      end else begin
        want = kept_matches.pop_front();
        if (result.kept_query_index !== want.kept_query_index ||
            result.kept_train_index !== want.kept_train_index ||
            result.kept_distance !== want.kept_distance) begin
          if (mismatches < MAX_REPORTS) begin
            $display("result mismatch: expected q=%0d t=%0d d=%h, got q=%0d t=%0d d=%h",
                     want.kept_query_index, want.kept_train_index, want.kept_distance,
                     result.kept_query_index, result.kept_train_index, result.kept_distance);
          end
          mismatches++;
        end
      end
    end
    // A transfer or a result restarts the count; the reset sweep fits well inside the limit.
    if (rst || (start && busy === 1'b0) || result_valid === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("match_cross_check_filter test failed");
      $finish;
    end
  end

endmodule
